// File: design/bsfr_pkg.sv
package bsfr_pkg;

  // Largest buffer size the length register may ask for
  localparam int unsigned MAX_FRAME = 4096;

  // Default depth of the queue between front and back
  localparam int unsigned FIFO_DEPTH_DEF = 4;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 12;
  localparam int unsigned MLEN_W = 13;
  localparam int unsigned IDX_W  = 2;

  // Stuffing codes
  localparam logic [BYTE_W-1:0] ESC_BYTE = 8'hfd;
  localparam logic [BYTE_W-1:0] ALT_BYTE = 8'hff;

  // Register indexes
  localparam logic [IDX_W-1:0] CFG_HEAD = 2'd0;
  localparam logic [IDX_W-1:0] CFG_TAIL = 2'd1;
  localparam logic [IDX_W-1:0] CFG_MLEN = 2'd2;

  // Register reset values
  localparam logic [BYTE_W-1:0] HEAD_RST = 8'hff;
  localparam logic [BYTE_W-1:0] TAIL_RST = 8'hfe;
  localparam logic [MLEN_W-1:0] MLEN_RST = 13'd4096;

  // Receiver mode, one-hot
  typedef enum logic [2:0] {
    MODE_HUNT = 3'b001,
    MODE_BODY = 3'b010,
    MODE_ESC  = 3'b100
  } bsfr_mode_e;

  // One result item
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_end;
    logic [CNT_W-1:0]  frame_length;
    logic              truncated;
  } bsfr_res_t;

  // Stored-byte limit: clamp to [2, MAX_FRAME], minus one, cap to count range
  function automatic logic [CNT_W-1:0] bsfr_limit(input logic [MLEN_W-1:0] mlen);
    logic [31:0] m;
    m = 32'(mlen);
    if (m < 32'd2) m = 32'd2;
    if (m > 32'(MAX_FRAME)) m = 32'(MAX_FRAME);
    m = m - 32'd1;
    if (m > 32'((1 << CNT_W) - 1)) m = 32'((1 << CNT_W) - 1);
    return m[CNT_W-1:0];
  endfunction

endpackage

// File: design/byte_stuffed_frame_receiver_unit.sv
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+------------------------------------
// rx       | in        | rx_valid_i / rx_ready_o  | rx_byte_i
// res      | out       | res_valid_o / res_ready_i| payload_byte_o, frame_end_o,
//          |           |                          | frame_length_o, truncated_o
// cfg      | in        | cfg_we_i (no wait)       | cfg_idx_i, cfg_data_i
//
// One raw byte per cycle while the result queue is not full; the front decodes it in the cycle it is taken.
// A result is written into the queue at the edge that takes its byte, then moves on into the output register.
// rx_ready_o drops only when the result queue (FIFO_DEPTH entries) is full.
// Reset clears mode, count, queue and output valid; registers take defaults.
module byte_stuffed_frame_receiver_unit import bsfr_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [MLEN_W-1:0] cfg_data_i,
  input  logic              rx_valid_i,
  output logic              rx_ready_o,
  input  logic [BYTE_W-1:0] rx_byte_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [BYTE_W-1:0] payload_byte_o,
  output logic              frame_end_o,
  output logic [CNT_W-1:0]  frame_length_o,
  output logic              truncated_o
);

  logic      q_full, q_push, q_valid, q_pop;
  bsfr_res_t q_wdata, q_rdata;

  bsfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  bsfr_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_rdata)
  );

  bsfr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_data_i       (q_rdata),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready_i),
    .payload_byte_o (payload_byte_o),
    .frame_end_o    (frame_end_o),
    .frame_length_o (frame_length_o),
    .truncated_o    (truncated_o)
  );

endmodule

// File: design/bsfr_front.sv
module bsfr_front import bsfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [MLEN_W-1:0] cfg_data_i,
  // raw bytes
  input  logic              rx_valid_i,
  output logic              rx_ready_o,
  input  logic [BYTE_W-1:0] rx_byte_i,
  // toward the queue
  input  logic              q_full_i,
  output logic              q_push_o,
  output bsfr_res_t         q_data_o
);

  logic [BYTE_W-1:0] head_q, tail_q;
  logic [CNT_W-1:0]  limit_q;
  bsfr_mode_e        mode_q, mode_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              acc;
  logic              push;
  bsfr_res_t         res;

  // Configuration registers; the limit is worked out once at write time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= HEAD_RST;
      tail_q  <= TAIL_RST;
      limit_q <= bsfr_limit(MLEN_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEAD: head_q  <= cfg_data_i[BYTE_W-1:0];
        CFG_TAIL: tail_q  <= cfg_data_i[BYTE_W-1:0];
        CFG_MLEN: limit_q <= bsfr_limit(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Input stalls while the queue is full, even for bytes that yield no result
  assign rx_ready_o = !q_full_i;
  assign acc        = rx_valid_i && rx_ready_o;

  // Byte classification and mode update
  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    push   = 1'b0;
    res    = '0;
    case (mode_q)
      MODE_BODY: begin
        if (rx_byte_i == ESC_BYTE && cnt_q < limit_q) begin
          mode_d = MODE_ESC;
        end else if (rx_byte_i == tail_q || cnt_q >= limit_q) begin
          push             = 1'b1;
          res.frame_end    = 1'b1;
          res.frame_length = cnt_q;
          res.truncated    = (rx_byte_i != tail_q);
          mode_d           = MODE_HUNT;
          cnt_d            = '0;
        end else begin
          push             = 1'b1;
          res.payload_byte = rx_byte_i;
          cnt_d            = cnt_q + 1'b1;
        end
      end
      MODE_ESC: begin
        mode_d = MODE_BODY;
        if (rx_byte_i == ESC_BYTE || rx_byte_i == ALT_BYTE) begin
          push             = 1'b1;
          res.payload_byte = rx_byte_i;
          cnt_d            = cnt_q + 1'b1;
        end
      end
      default: begin
        // hunting, or a mode code with no meaning
        mode_d = MODE_HUNT;
        if (rx_byte_i == head_q) begin
          mode_d = MODE_BODY;
          cnt_d  = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_HUNT;
      cnt_q  <= '0;
    end else if (acc) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  assign q_push_o = acc && push;
  assign q_data_o = res;

endmodule

// File: design/bsfr_fifo.sv
module bsfr_fifo import bsfr_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  bsfr_res_t data_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      pop_i,
  output bsfr_res_t data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W_F = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]   LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W_F-1:0] FULL = CNT_W_F'(DEPTH);

  bsfr_res_t          mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W_F-1:0] fill_q;
  logic               do_pop;

  assign full_o  = (fill_q == FULL);
  assign valid_o = (fill_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

// File: design/bsfr_back.sv
module bsfr_back import bsfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  input  bsfr_res_t         q_data_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [BYTE_W-1:0] payload_byte_o,
  output logic              frame_end_o,
  output logic [CNT_W-1:0]  frame_length_o,
  output logic              truncated_o
);

  logic      valid_q;
  bsfr_res_t res_q;

  // Load a new result when the register is empty or being drained
  assign q_pop_o = q_valid_i && (!valid_q || res_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || res_ready_i) begin
      valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= q_data_i;
    end
  end

  assign res_valid_o    = valid_q;
  assign payload_byte_o = res_q.payload_byte;
  assign frame_end_o    = res_q.frame_end;
  assign frame_length_o = res_q.frame_length;
  assign truncated_o    = res_q.truncated;

endmodule
